### rtl/slss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slss_pkg
// Shared types and constants for the signed literal sum scanner.
// ----------------------------------------------------------------------------
package slss_pkg;

    // Internal arithmetic width of the total and of the literal magnitude
    localparam int VALUE_WIDTH = 64;
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int OUT_W       = 64;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Number base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_BIN = 2'd3;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_stream;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] running_total;
        logic signed [OUT_W-1:0] literal_value;
        logic [1:0]              literal_base;
        logic                    literal_done;
        logic                    final_total;
    } t_result;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic [3:0] digit;      // value of a hex digit, 0-15
        logic       is_dec;     // '0'..'9'
        logic       is_hex;     // any hex digit
        logic       is_ws;
        logic       is_minus;
        logic       is_x;
        logic       is_b;
        logic       eos;
    } t_cls;

    typedef struct packed {
        logic push;
        t_cls data;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage : slss_pkg
`default_nettype wire

### rtl/slss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slss_front
// Accepts characters and classifies them into a registered request for the
// queue.
// ----------------------------------------------------------------------------
module slss_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire slss_pkg::t_item i_item,
    output logic                 o_stall,
    input  wire slss_pkg::t_qstat i_qstat,
    output slss_pkg::t_push      o_push
);
    import slss_pkg::*;

    logic  r_vld, n_vld;
    t_cls  r_cls, n_cls;
    logic  accept, push;
    logic [7:0] c;

    assign push    = r_vld && !i_qstat.full;
    assign o_stall = r_vld && i_qstat.full;
    assign accept  = i_valid && !o_stall;
    assign c       = i_item.char_code;

    always_comb begin
        n_cls          = '0;
        n_cls.eos      = i_item.end_of_stream;
        n_cls.is_ws    = (c inside {[CH_TAB:CH_CR], CH_SPACE});
        n_cls.is_minus = (c == CH_MINUS);
        n_cls.is_x     = (c == CH_LO_X) || (c == CH_UP_X);
        n_cls.is_b     = (c == CH_LO_B) || (c == CH_UP_B);
        if (c inside {[CH_0:CH_9]}) begin
            n_cls.is_dec = 1'b1;
            n_cls.is_hex = 1'b1;
            n_cls.digit  = c[3:0];
        end else if (c inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]}) begin
            // 'a' and 'A' have low nibble 1
            n_cls.is_hex = 1'b1;
            n_cls.digit  = c[3:0] + 4'd9;
        end
        n_vld = accept || (r_vld && !push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_push.push = push;
    assign o_push.data = r_cls;

endmodule : slss_front
`default_nettype wire

### rtl/slss_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slss_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module slss_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire slss_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output slss_pkg::t_qstat      o_qstat,
    output slss_pkg::t_cls        o_head
);
    import slss_pkg::*;

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push       = i_push.push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_comb begin
        n_wr  = (r_wr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
        n_rd  = (r_rd == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
        n_cnt = r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= n_wr;
            if (do_pop)  r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

endmodule : slss_queue
`default_nettype wire

### rtl/slss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slss_back
// Parse state, magnitude multiply-add, total update and output register.
// ----------------------------------------------------------------------------
module slss_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire slss_pkg::t_qstat  i_qstat,
    input  wire slss_pkg::t_cls    i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    output slss_pkg::t_result      o_result,
    input  wire logic              i_stall
);
    import slss_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ZERO   = 2'd1;
    localparam logic [1:0] PH_PREFIX = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;
    localparam int         ACC_W     = VALUE_WIDTH + 4;

    logic [1:0]               r_ph, n_ph;
    logic [1:0]               r_base, n_base;
    logic                     r_sg, n_sg;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic signed [VALUE_WIDTH-1:0] r_total, n_total;

    logic                     r_ovld, n_ovld;
    t_result                  r_res, n_res;

    logic                     emit, fresh, valid_dig, close1, close2;
    logic [ACC_W-1:0]         mag_w, acc;
    logic [VALUE_WIDTH-1:0]   v1, v2, add1, add2, lit_v;
    logic [1:0]               lit_b;
    logic [MAG_W-1:0]         dig_mag;

    assign o_pop   = !i_qstat.empty && (!r_ovld || !i_stall);
    assign dig_mag = MAG_W'(i_head.digit);

    always_comb begin
        case (r_base)
            BASE_HEX: valid_dig = i_head.is_hex;
            BASE_OCT: valid_dig = i_head.is_dec && !i_head.digit[3];
            BASE_BIN: valid_dig = i_head.is_dec && (i_head.digit[3:1] == 3'd0);
            default:  valid_dig = i_head.is_dec;
        endcase
    end

    // magnitude times radix plus digit, with room to spot overflow
    always_comb begin
        mag_w = ACC_W'(r_mag);
        case (r_base)
            BASE_HEX: acc = (mag_w << 4);
            BASE_OCT: acc = (mag_w << 3);
            BASE_BIN: acc = (mag_w << 1);
            default:  acc = (mag_w << 3) + (mag_w << 1);
        endcase
        acc = acc + ACC_W'(i_head.digit);
    end

    always_comb begin
        n_ph   = r_ph;
        n_base = r_base;
        n_sg   = r_sg;
        n_mag  = r_mag;
        fresh  = 1'b0;
        close1 = 1'b0;
        v1     = r_sg ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(r_mag)) : VALUE_WIDTH'(r_mag);

        case (r_ph)
            PH_ZERO: begin
                if (i_head.is_x) begin
                    n_base = BASE_HEX;
                    n_ph   = PH_PREFIX;
                end else if (i_head.is_b) begin
                    n_base = BASE_BIN;
                    n_ph   = PH_PREFIX;
                end else if (i_head.is_dec && !i_head.digit[3]) begin
                    n_base = BASE_OCT;
                    n_ph   = PH_DIGITS;
                    n_mag  = dig_mag;
                end else begin
                    fresh = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (valid_dig) begin
                    n_ph  = PH_DIGITS;
                    n_mag = dig_mag;
                end else begin
                    fresh = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (valid_dig) begin
                    // saturate at the largest positive value
                    if (acc > ACC_W'({MAG_W{1'b1}})) begin
                        n_mag = {MAG_W{1'b1}};
                    end else begin
                        n_mag = acc[MAG_W-1:0];
                    end
                end else begin
                    close1 = 1'b1;
                    fresh  = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // closing or failing character is looked at again from idle
        if (fresh) begin
            n_ph   = PH_IDLE;
            n_base = BASE_DEC;
            n_mag  = '0;
            if (i_head.is_ws) begin
                n_sg = 1'b0;
            end else if (i_head.is_minus) begin
                n_sg = 1'b1;
            end else if (i_head.is_dec && (i_head.digit != 4'd0)) begin
                n_ph  = PH_DIGITS;
                n_mag = dig_mag;
            end else if (i_head.is_dec) begin
                n_ph = PH_ZERO;
            end
        end

        close2 = i_head.eos && (n_ph == PH_DIGITS);
        v2     = n_sg ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(n_mag)) : VALUE_WIDTH'(n_mag);
        add1   = close1 ? v1 : '0;
        add2   = close2 ? v2 : '0;
        n_total = r_total + $signed(add1) + $signed(add2);

        if (close2) begin
            lit_v = v2;
            lit_b = n_base;
        end else if (close1) begin
            lit_v = v1;
            lit_b = r_base;
        end else begin
            lit_v = '0;
            lit_b = BASE_DEC;
        end
        emit = close1 || close2 || i_head.eos;

        n_res.running_total = OUT_W'(n_total);
        n_res.literal_value = OUT_W'($signed(lit_v));
        n_res.literal_base  = lit_b;
        n_res.literal_done  = close1 || close2;
        n_res.final_total   = i_head.eos;

        n_ovld = (o_pop && emit) || (r_ovld && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_IDLE;
            r_base  <= BASE_DEC;
            r_sg    <= 1'b0;
            r_mag   <= '0;
            r_total <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_ovld <= n_ovld;
            if (o_pop) begin
                if (i_head.eos) begin
                    r_ph    <= PH_IDLE;
                    r_base  <= BASE_DEC;
                    r_sg    <= 1'b0;
                    r_mag   <= '0;
                    r_total <= '0;
                end else begin
                    r_ph    <= n_ph;
                    r_base  <= n_base;
                    r_sg    <= n_sg;
                    r_mag   <= n_mag;
                    r_total <= n_total;
                end
            end
        end
        if (o_pop && emit) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_ovld;
    assign o_result = r_res;

endmodule : slss_back
`default_nettype wire

### rtl/signed_literal_sum_scanner.sv
`default_nettype none
// A result passes the front register, the queue and the output register of
// the back part after its character is accepted. Throughput: one character
// per cycle while o_stall is low; the front-to-back queue holds two requests.
// Reset (i_rst_n low at a clock edge) empties the pipeline and queue and
// returns parse state and total to zero.
// ----------------------------------------------------------------------------
// signed_literal_sum_scanner
// Finds integer literals in a character stream and keeps their signed sum.
// ----------------------------------------------------------------------------
module signed_literal_sum_scanner (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire slss_pkg::t_item   i_item,
    output logic                   o_stall,
    output logic                   o_valid,
    output slss_pkg::t_result      o_result,
    input  wire logic              i_stall
);
    import slss_pkg::*;

    t_push  push;
    t_qstat qstat;
    t_cls   head;
    logic   pop;

    slss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .i_qstat (qstat),
        .o_push  (push)
    );

    slss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    slss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule : signed_literal_sum_scanner
`default_nettype wire
